### src/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants for the wall segment projector
// Widths of every pipeline value, structs between blocks, sine table.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int ANGLE_STEPS   = 360;
  localparam int QUARTER_TURN  = 90;
  localparam int HALF_TURN     = 180;
  localparam int THREE_QUARTER = 270;
  localparam int ANGLE_W       = 9;
  localparam int QUARTER_IDX_W = 7;

  localparam int COORD_W     = 16;
  localparam int LOOK_W      = 8;
  localparam int DIFF_W      = 17;
  localparam int TRIG_W      = 16;
  localparam int PROD_W      = 33;
  localparam int ROT_SUM_W   = 34;
  localparam int ROT_SHIFT   = 14;
  localparam int ROT_W       = 19;
  localparam int LOOK_SHIFT  = 5;
  localparam int LOOK_PROD_W = 27;
  localparam int Z_SUM_W     = 28;
  localparam int VAL_W       = 25;

  localparam int CLIP_SHIFT  = 16;
  localparam int CLIP_NUM_W  = 34;
  localparam int CLIP_DEN_W  = 19;
  localparam int RATIO_W     = 16;
  localparam int CLIP_PROD_W = 42;

  localparam int PROJ_SCALE  = 200;
  localparam int PROJ_NUM_W  = 33;
  localparam int PROJ_DEN_W  = 19;
  localparam int PROJ_SUM_W  = 35;
  localparam int LANES       = 6;
  localparam int OUT_W       = 25;
  localparam int OUT_MAX     = 16777215;
  localparam int OUT_MIN     = -16777216;

  localparam int DEFAULT_HALF_SCREEN_W = 320;
  localparam int DEFAULT_HALF_SCREEN_H = 240;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VIEWER_X     = 3'd0,
    CFG_VIEWER_Y     = 3'd1,
    CFG_VIEWER_Z     = 3'd2,
    CFG_VIEWER_ANGLE = 3'd3,
    CFG_VIEWER_LOOK  = 3'd4
  } cfg_index_t;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [ANGLE_W-1:0] angle;
    logic signed [LOOK_W-1:0]  look;
  } viewer_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] floor_h;
    logic signed [COORD_W-1:0] height;
    logic                      swap;
  } wall_t;

  typedef struct packed {
    val_t px;
    val_t py;
    val_t zb;
    val_t zt;
  } point_t;

  typedef struct packed {
    logic                  valid;
    logic                  visible;
    logic                  clip0;
    logic                  clip_any;
    point_t                e0;
    point_t                e1;
    logic [CLIP_NUM_W-1:0] clip_num;
    logic [CLIP_DEN_W-1:0] clip_den;
  } xform_t;

  typedef struct packed {
    logic   valid;
    logic   visible;
    logic   clip0;
    logic   clip_any;
    point_t e0;
    point_t e1;
    point_t diff;
  } clip_side_t;

  typedef struct packed {
    logic             valid;
    logic             visible;
    logic [LANES-1:0] sign;
  } proj_side_t;

  typedef logic signed [TRIG_W-1:0] quarter_table_t [QUARTER_TURN+1];

  // shift and subtract quotient, used only while building the table
  function automatic u64_t udiv64(u64_t n, u64_t d);
    u64_t q;
    u64_t r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(16384*sin(k degrees)), k in 0..90, by integer Taylor series
  function automatic logic signed [TRIG_W-1:0] quarter_sine(int unsigned k);
    u64_t   x;
    u64_t   term;
    longint acc;
    u64_t   div;
    x    = u64_t'(k) * RAD_PER_DEG_Q30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      div  = u64_t'((2 * n) * (2 * n + 1));
      term = udiv64(term, div);
      if ((n & 1) == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return TRIG_W'((u64_t'(acc) + 64'd32768) >> 16);
  endfunction

  function automatic quarter_table_t build_quarter_table();
    quarter_table_t t;
    for (int d = 0; d <= QUARTER_TURN; d++) t[d] = quarter_sine(d);
    return t;
  endfunction

  localparam quarter_table_t QUARTER_TABLE = build_quarter_table();

endpackage

### src/wsp_delay.sv
// ----------------------------------------------------------------------------
// wsp_delay: fixed-length register line
// Carries side data alongside a pipelined divider.
// ----------------------------------------------------------------------------
module wsp_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

### src/wsp_div.sv
// ----------------------------------------------------------------------------
// wsp_div: pipelined unsigned restoring divider
// One quotient bit per stage, NUM_W stages, a new word every cycle.
// ----------------------------------------------------------------------------
module wsp_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 19
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem_s [NUM_W+1];
  logic [NUM_W-1:0] num_s [NUM_W+1];
  logic [NUM_W-1:0] quo_s [NUM_W+1];
  logic [DEN_W-1:0] den_s [NUM_W+1];

  assign rem_s[0] = '0;
  assign num_s[0] = num;
  assign quo_s[0] = '0;
  assign den_s[0] = den;

  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem_s[i], num_s[i][NUM_W-1]};
    assign diff  = trial - {1'b0, den_s[i]};
    assign take  = (trial >= {1'b0, den_s[i]});

    always_ff @(posedge clk) begin
      rem_s[i+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_s[i+1] <= num_s[i] << 1;
      quo_s[i+1] <= {quo_s[i][NUM_W-2:0], take};
      den_s[i+1] <= den_s[i];
    end
  end

  assign quo = quo_s[NUM_W];

endmodule

### src/wsp_xform.sv
// ----------------------------------------------------------------------------
// wsp_xform: viewer transform front end
// Translate, rotate, add look tilt, cull and set up the near clip division.
// ----------------------------------------------------------------------------
module wsp_xform (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  wsp_pkg::wall_t   wall,
  input  wsp_pkg::viewer_t viewer,
  output wsp_pkg::xform_t  xout
);

  localparam logic signed [wsp_pkg::ROT_SUM_W-1:0] ROT_BIAS =
    wsp_pkg::ROT_SUM_W'((1 << wsp_pkg::ROT_SHIFT) - 1);
  localparam logic signed [wsp_pkg::ROT_SUM_W-1:0] ROT_ZERO = wsp_pkg::ROT_SUM_W'(0);
  localparam logic signed [wsp_pkg::Z_SUM_W-1:0] Z_BIAS =
    wsp_pkg::Z_SUM_W'((1 << wsp_pkg::LOOK_SHIFT) - 1);
  localparam logic signed [wsp_pkg::Z_SUM_W-1:0] Z_ZERO = wsp_pkg::Z_SUM_W'(0);

  // fold a whole-degree heading onto the quarter-wave table
  function automatic logic signed [wsp_pkg::TRIG_W-1:0] sine_of(
    input logic [wsp_pkg::ANGLE_W-1:0] a
  );
    logic [wsp_pkg::ANGLE_W-1:0]       idx;
    logic signed [wsp_pkg::TRIG_W-1:0] mag;
    logic                              neg;
    if (a <= wsp_pkg::ANGLE_W'(wsp_pkg::QUARTER_TURN)) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= wsp_pkg::ANGLE_W'(wsp_pkg::HALF_TURN)) begin
      idx = wsp_pkg::ANGLE_W'(wsp_pkg::HALF_TURN) - a;
      neg = 1'b0;
    end else if (a <= wsp_pkg::ANGLE_W'(wsp_pkg::THREE_QUARTER)) begin
      idx = a - wsp_pkg::ANGLE_W'(wsp_pkg::HALF_TURN);
      neg = 1'b1;
    end else begin
      idx = wsp_pkg::ANGLE_W'(wsp_pkg::ANGLE_STEPS) - a;
      neg = 1'b1;
    end
    mag = wsp_pkg::QUARTER_TABLE[idx[wsp_pkg::QUARTER_IDX_W-1:0]];
    return neg ? -mag : mag;
  endfunction

  // sine and cosine of the heading, refreshed every cycle
  logic        [wsp_pkg::ANGLE_W-1:0] cos_index;
  logic signed [wsp_pkg::TRIG_W-1:0]  sin_q;
  logic signed [wsp_pkg::TRIG_W-1:0]  cos_q;

  assign cos_index = (viewer.angle >= wsp_pkg::ANGLE_W'(wsp_pkg::ANGLE_STEPS -
                                                       wsp_pkg::QUARTER_TURN))
                   ? viewer.angle - wsp_pkg::ANGLE_W'(wsp_pkg::ANGLE_STEPS -
                                                       wsp_pkg::QUARTER_TURN)
                   : viewer.angle + wsp_pkg::ANGLE_W'(wsp_pkg::QUARTER_TURN);

  always_ff @(posedge clk) begin
    sin_q <= sine_of(viewer.angle);
    cos_q <= sine_of(cos_index);
  end

  // stage 1: translate and swap
  logic                               v1;
  logic signed [wsp_pkg::DIFF_W-1:0]  ex0_1, ey0_1, ex1_1, ey1_1, fr_1;
  logic signed [wsp_pkg::COORD_W-1:0] ht_1;
  logic signed [wsp_pkg::DIFF_W-1:0]  dxa, dya, dxb, dyb;

  always_comb begin
    dxa = wsp_pkg::DIFF_W'(wall.x1) - wsp_pkg::DIFF_W'(viewer.x);
    dya = wsp_pkg::DIFF_W'(wall.y1) - wsp_pkg::DIFF_W'(viewer.y);
    dxb = wsp_pkg::DIFF_W'(wall.x2) - wsp_pkg::DIFF_W'(viewer.x);
    dyb = wsp_pkg::DIFF_W'(wall.y2) - wsp_pkg::DIFF_W'(viewer.y);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    ex0_1 <= wall.swap ? dxb : dxa;
    ey0_1 <= wall.swap ? dyb : dya;
    ex1_1 <= wall.swap ? dxa : dxb;
    ey1_1 <= wall.swap ? dya : dyb;
    fr_1  <= wsp_pkg::DIFF_W'(wall.floor_h) - wsp_pkg::DIFF_W'(viewer.z);
    ht_1  <= wall.height;
  end

  // stage 2: rotation products
  logic                               v2;
  logic signed [wsp_pkg::PROD_W-1:0]  xc0, ys0, yc0, xs0, xc1, ys1, yc1, xs1;
  logic signed [wsp_pkg::DIFF_W-1:0]  fr_2;
  logic signed [wsp_pkg::COORD_W-1:0] ht_2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  always_ff @(posedge clk) begin
    xc0  <= wsp_pkg::PROD_W'(ex0_1) * wsp_pkg::PROD_W'(cos_q);
    ys0  <= wsp_pkg::PROD_W'(ey0_1) * wsp_pkg::PROD_W'(sin_q);
    yc0  <= wsp_pkg::PROD_W'(ey0_1) * wsp_pkg::PROD_W'(cos_q);
    xs0  <= wsp_pkg::PROD_W'(ex0_1) * wsp_pkg::PROD_W'(sin_q);
    xc1  <= wsp_pkg::PROD_W'(ex1_1) * wsp_pkg::PROD_W'(cos_q);
    ys1  <= wsp_pkg::PROD_W'(ey1_1) * wsp_pkg::PROD_W'(sin_q);
    yc1  <= wsp_pkg::PROD_W'(ey1_1) * wsp_pkg::PROD_W'(cos_q);
    xs1  <= wsp_pkg::PROD_W'(ex1_1) * wsp_pkg::PROD_W'(sin_q);
    fr_2 <= fr_1;
    ht_2 <= ht_1;
  end

  // stage 3: sum and scale back, rounding toward zero
  logic                                 v3;
  logic signed [wsp_pkg::ROT_W-1:0]     px0_3, py0_3, px1_3, py1_3;
  logic signed [wsp_pkg::DIFF_W-1:0]    fr_3;
  logic signed [wsp_pkg::COORD_W-1:0]   ht_3;
  logic signed [wsp_pkg::ROT_SUM_W-1:0] rx0, ry0, rx1, ry1;
  logic signed [wsp_pkg::ROT_SUM_W-1:0] rx0_b, ry0_b, rx1_b, ry1_b;

  always_comb begin
    rx0 = wsp_pkg::ROT_SUM_W'(xc0) - wsp_pkg::ROT_SUM_W'(ys0);
    ry0 = wsp_pkg::ROT_SUM_W'(yc0) + wsp_pkg::ROT_SUM_W'(xs0);
    rx1 = wsp_pkg::ROT_SUM_W'(xc1) - wsp_pkg::ROT_SUM_W'(ys1);
    ry1 = wsp_pkg::ROT_SUM_W'(yc1) + wsp_pkg::ROT_SUM_W'(xs1);
    rx0_b = rx0 + (rx0[wsp_pkg::ROT_SUM_W-1] ? ROT_BIAS : ROT_ZERO);
    ry0_b = ry0 + (ry0[wsp_pkg::ROT_SUM_W-1] ? ROT_BIAS : ROT_ZERO);
    rx1_b = rx1 + (rx1[wsp_pkg::ROT_SUM_W-1] ? ROT_BIAS : ROT_ZERO);
    ry1_b = ry1 + (ry1[wsp_pkg::ROT_SUM_W-1] ? ROT_BIAS : ROT_ZERO);
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
  end

  always_ff @(posedge clk) begin
    px0_3 <= wsp_pkg::ROT_W'(rx0_b >>> wsp_pkg::ROT_SHIFT);
    py0_3 <= wsp_pkg::ROT_W'(ry0_b >>> wsp_pkg::ROT_SHIFT);
    px1_3 <= wsp_pkg::ROT_W'(rx1_b >>> wsp_pkg::ROT_SHIFT);
    py1_3 <= wsp_pkg::ROT_W'(ry1_b >>> wsp_pkg::ROT_SHIFT);
    fr_3  <= fr_2;
    ht_3  <= ht_2;
  end

  // stage 4: look tilt products
  logic                                   v4;
  logic signed [wsp_pkg::ROT_W-1:0]       px0_4, py0_4, px1_4, py1_4;
  logic signed [wsp_pkg::LOOK_PROD_W-1:0] lp0_4, lp1_4;
  logic signed [wsp_pkg::DIFF_W-1:0]      fr_4;
  logic signed [wsp_pkg::COORD_W-1:0]     ht_4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
  end

  always_ff @(posedge clk) begin
    px0_4 <= px0_3;
    py0_4 <= py0_3;
    px1_4 <= px1_3;
    py1_4 <= py1_3;
    lp0_4 <= wsp_pkg::LOOK_PROD_W'(viewer.look) * wsp_pkg::LOOK_PROD_W'(py0_3);
    lp1_4 <= wsp_pkg::LOOK_PROD_W'(viewer.look) * wsp_pkg::LOOK_PROD_W'(py1_3);
    fr_4  <= fr_3;
    ht_4  <= ht_3;
  end

  // stage 5: heights, cull, clip division setup
  logic signed [wsp_pkg::Z_SUM_W-1:0] zs0, zs1, zs0_b, zs1_b;
  logic signed [wsp_pkg::VAL_W-1:0]   zb0, zb1;
  logic                               clip0, clip1;
  logic signed [wsp_pkg::ROT_W-1:0]   py_near, py_far;
  logic signed [wsp_pkg::ROT_W:0]     neg_near;
  logic signed [wsp_pkg::ROT_W-1:0]   span;
  wsp_pkg::xform_t                    x5;

  always_comb begin
    zs0 = (wsp_pkg::Z_SUM_W'(fr_4) <<< wsp_pkg::LOOK_SHIFT) + wsp_pkg::Z_SUM_W'(lp0_4);
    zs1 = (wsp_pkg::Z_SUM_W'(fr_4) <<< wsp_pkg::LOOK_SHIFT) + wsp_pkg::Z_SUM_W'(lp1_4);
    zs0_b = zs0 + (zs0[wsp_pkg::Z_SUM_W-1] ? Z_BIAS : Z_ZERO);
    zs1_b = zs1 + (zs1[wsp_pkg::Z_SUM_W-1] ? Z_BIAS : Z_ZERO);
    zb0 = wsp_pkg::VAL_W'(zs0_b >>> wsp_pkg::LOOK_SHIFT);
    zb1 = wsp_pkg::VAL_W'(zs1_b >>> wsp_pkg::LOOK_SHIFT);

    clip0 = (py0_4 < 1);
    clip1 = (py1_4 < 1);
    py_near  = clip0 ? py0_4 : py1_4;
    py_far   = clip0 ? py1_4 : py0_4;
    neg_near = -((wsp_pkg::ROT_W + 1)'(py_near));
    span     = py_far - py_near;

    x5.valid    = v4;
    x5.visible  = !(clip0 && clip1);
    x5.clip0    = clip0;
    x5.clip_any = clip0 || clip1;
    x5.e0.px    = wsp_pkg::VAL_W'(px0_4);
    x5.e0.py    = wsp_pkg::VAL_W'(py0_4);
    x5.e0.zb    = zb0;
    x5.e0.zt    = zb0 + wsp_pkg::VAL_W'(ht_4);
    x5.e1.px    = wsp_pkg::VAL_W'(px1_4);
    x5.e1.py    = wsp_pkg::VAL_W'(py1_4);
    x5.e1.zb    = zb1;
    x5.e1.zt    = zb1 + wsp_pkg::VAL_W'(ht_4);
    x5.clip_num = wsp_pkg::CLIP_NUM_W'(neg_near) << wsp_pkg::CLIP_SHIFT;
    x5.clip_den = wsp_pkg::CLIP_DEN_W'(span);
  end

  always_ff @(posedge clk) begin
    if (rst) xout <= '0;
    else xout <= x5;
  end

endmodule

### src/wall_segment_projector.sv
// ----------------------------------------------------------------------------
// wall_segment_projector: perspective projection of one wall with near clip
// Viewer transform, near-endpoint clip and screen projection, fully pipelined.
// ----------------------------------------------------------------------------
// Pipeline: 77 register stages between start and done (5 transform, 34 clip
//   divider, 4 clip and scale, 33 projection divider, 1 output).
// Throughput: one wall per clock outside reset, set by the bit-per-stage dividers.
// Reset: rst clears the viewer registers and every valid bit; busy is high
//   only during reset. The receiver cannot stall; done lasts one cycle.
// ----------------------------------------------------------------------------
module wall_segment_projector #(
  parameter int HALF_SCREEN_W = wsp_pkg::DEFAULT_HALF_SCREEN_W,
  parameter int HALF_SCREEN_H = wsp_pkg::DEFAULT_HALF_SCREEN_H
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [wsp_pkg::COORD_W-1:0]  wall_x1,
  input  logic signed [wsp_pkg::COORD_W-1:0]  wall_y1,
  input  logic signed [wsp_pkg::COORD_W-1:0]  wall_x2,
  input  logic signed [wsp_pkg::COORD_W-1:0]  wall_y2,
  input  logic signed [wsp_pkg::COORD_W-1:0]  sector_floor,
  input  logic signed [wsp_pkg::COORD_W-1:0]  sector_height,
  input  logic                                swap_ends,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [wsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // result channel
  output logic                                done,
  output logic                                visible,
  output logic signed [wsp_pkg::OUT_W-1:0]    screen_left_x,
  output logic signed [wsp_pkg::OUT_W-1:0]    screen_right_x,
  output logic signed [wsp_pkg::OUT_W-1:0]    bottom_left_y,
  output logic signed [wsp_pkg::OUT_W-1:0]    bottom_right_y,
  output logic signed [wsp_pkg::OUT_W-1:0]    top_left_y,
  output logic signed [wsp_pkg::OUT_W-1:0]    top_right_y
);

  localparam logic signed [wsp_pkg::CLIP_PROD_W-1:0] CLIP_BIAS =
    wsp_pkg::CLIP_PROD_W'((1 << wsp_pkg::CLIP_SHIFT) - 1);
  localparam logic signed [wsp_pkg::CLIP_PROD_W-1:0] CLIP_ZERO =
    wsp_pkg::CLIP_PROD_W'(0);
  localparam logic signed [wsp_pkg::PROJ_SUM_W-1:0] SAT_MAX =
    wsp_pkg::PROJ_SUM_W'(wsp_pkg::OUT_MAX);
  localparam logic signed [wsp_pkg::PROJ_SUM_W-1:0] SAT_MIN =
    wsp_pkg::PROJ_SUM_W'(wsp_pkg::OUT_MIN);

  // --------------------------------------------------------------------------
  // Viewer registers. A heading of 360 to 511 wraps once by 360; higher cfg_data bits are dropped.
  // --------------------------------------------------------------------------
  wsp_pkg::viewer_t               viewer;
  logic [wsp_pkg::ANGLE_W-1:0]    angle_wr;

  assign angle_wr = (cfg_data[wsp_pkg::ANGLE_W-1:0] >= wsp_pkg::ANGLE_W'(wsp_pkg::ANGLE_STEPS))
                  ? cfg_data[wsp_pkg::ANGLE_W-1:0] - wsp_pkg::ANGLE_W'(wsp_pkg::ANGLE_STEPS)
                  : cfg_data[wsp_pkg::ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      viewer <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wsp_pkg::CFG_VIEWER_X:     viewer.x <= cfg_data;
        wsp_pkg::CFG_VIEWER_Y:     viewer.y <= cfg_data;
        wsp_pkg::CFG_VIEWER_Z:     viewer.z <= cfg_data;
        wsp_pkg::CFG_VIEWER_ANGLE: viewer.angle <= angle_wr;
        wsp_pkg::CFG_VIEWER_LOOK:  viewer.look <= cfg_data[wsp_pkg::LOOK_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Command intake: the pipeline never stalls, so only reset holds it off.
  // --------------------------------------------------------------------------
  logic           in_valid;
  wsp_pkg::wall_t wall;

  assign busy     = rst;
  assign in_valid = start && !busy;

  always_comb begin
    wall.x1      = wall_x1;
    wall.y1      = wall_y1;
    wall.x2      = wall_x2;
    wall.y2      = wall_y2;
    wall.floor_h = sector_floor;
    wall.height  = sector_height;
    wall.swap    = swap_ends;
  end

  wsp_pkg::xform_t xo;

  wsp_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .wall     (wall),
    .viewer   (viewer),
    .xout     (xo)
  );

  // --------------------------------------------------------------------------
  // Clip ratio: s = floor(65536 * -d_near / (d_far - d_near)). The endpoint
  // words and the far-minus-near differences ride a matching delay line.
  // --------------------------------------------------------------------------
  wsp_pkg::point_t               near_pt, far_pt;
  wsp_pkg::clip_side_t           cside_in, cside_out;
  logic [wsp_pkg::CLIP_NUM_W-1:0] clip_quo;

  always_comb begin
    near_pt = xo.clip0 ? xo.e0 : xo.e1;
    far_pt  = xo.clip0 ? xo.e1 : xo.e0;
    cside_in.valid    = xo.valid;
    cside_in.visible  = xo.visible;
    cside_in.clip0    = xo.clip0;
    cside_in.clip_any = xo.clip_any;
    cside_in.e0       = xo.e0;
    cside_in.e1       = xo.e1;
    cside_in.diff.px  = far_pt.px - near_pt.px;
    cside_in.diff.py  = far_pt.py - near_pt.py;
    cside_in.diff.zb  = far_pt.zb - near_pt.zb;
    cside_in.diff.zt  = far_pt.zt - near_pt.zt;
  end

  wsp_div #(
    .NUM_W (wsp_pkg::CLIP_NUM_W),
    .DEN_W (wsp_pkg::CLIP_DEN_W)
  ) u_clip_div (
    .clk (clk),
    .num (xo.clip_num),
    .den (xo.clip_den),
    .quo (clip_quo)
  );

  wsp_delay #(
    .W     ($bits(wsp_pkg::clip_side_t)),
    .DEPTH (wsp_pkg::CLIP_NUM_W)
  ) u_clip_delay (
    .clk (clk),
    .rst (rst),
    .d   (cside_in),
    .q   (cside_out)
  );

  // --------------------------------------------------------------------------
  // Clip stage 1: ratio times difference for the four near-endpoint values.
  // The ratio stays below 65536 whenever a clip is needed.
  // --------------------------------------------------------------------------
  logic signed [wsp_pkg::RATIO_W:0]       ratio;
  wsp_pkg::clip_side_t                    c1_side;
  logic signed [wsp_pkg::CLIP_PROD_W-1:0] c1_px, c1_py, c1_zb, c1_zt;

  assign ratio = $signed({1'b0, clip_quo[wsp_pkg::RATIO_W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) c1_side <= '0;
    else c1_side <= cside_out;
  end

  always_ff @(posedge clk) begin
    c1_px <= wsp_pkg::CLIP_PROD_W'(ratio) * wsp_pkg::CLIP_PROD_W'(cside_out.diff.px);
    c1_py <= wsp_pkg::CLIP_PROD_W'(ratio) * wsp_pkg::CLIP_PROD_W'(cside_out.diff.py);
    c1_zb <= wsp_pkg::CLIP_PROD_W'(ratio) * wsp_pkg::CLIP_PROD_W'(cside_out.diff.zb);
    c1_zt <= wsp_pkg::CLIP_PROD_W'(ratio) * wsp_pkg::CLIP_PROD_W'(cside_out.diff.zt);
  end

  // --------------------------------------------------------------------------
  // Clip stage 2: v + s*(far - v) / 65536 toward zero, then put the clipped
  // point back in place. A clipped depth below 1 is forced to 1.
  // --------------------------------------------------------------------------
  wsp_pkg::point_t                        c_near, c_new, c2_e0, c2_e1;
  logic signed [wsp_pkg::CLIP_PROD_W-1:0] s_px, s_py, s_zb, s_zt;
  logic                                   c2_valid, c2_visible;

  always_comb begin
    c_near = c1_side.clip0 ? c1_side.e0 : c1_side.e1;
    s_px = (wsp_pkg::CLIP_PROD_W'(c_near.px) <<< wsp_pkg::CLIP_SHIFT) + c1_px;
    s_py = (wsp_pkg::CLIP_PROD_W'(c_near.py) <<< wsp_pkg::CLIP_SHIFT) + c1_py;
    s_zb = (wsp_pkg::CLIP_PROD_W'(c_near.zb) <<< wsp_pkg::CLIP_SHIFT) + c1_zb;
    s_zt = (wsp_pkg::CLIP_PROD_W'(c_near.zt) <<< wsp_pkg::CLIP_SHIFT) + c1_zt;
    s_px = s_px + (s_px[wsp_pkg::CLIP_PROD_W-1] ? CLIP_BIAS : CLIP_ZERO);
    s_py = s_py + (s_py[wsp_pkg::CLIP_PROD_W-1] ? CLIP_BIAS : CLIP_ZERO);
    s_zb = s_zb + (s_zb[wsp_pkg::CLIP_PROD_W-1] ? CLIP_BIAS : CLIP_ZERO);
    s_zt = s_zt + (s_zt[wsp_pkg::CLIP_PROD_W-1] ? CLIP_BIAS : CLIP_ZERO);
    c_new.px = wsp_pkg::VAL_W'(s_px >>> wsp_pkg::CLIP_SHIFT);
    c_new.py = wsp_pkg::VAL_W'(s_py >>> wsp_pkg::CLIP_SHIFT);
    c_new.zb = wsp_pkg::VAL_W'(s_zb >>> wsp_pkg::CLIP_SHIFT);
    c_new.zt = wsp_pkg::VAL_W'(s_zt >>> wsp_pkg::CLIP_SHIFT);
    if (c_new.py < 1) c_new.py = wsp_pkg::VAL_W'(1);

    c2_e0 = c1_side.e0;
    c2_e1 = c1_side.e1;
    if (c1_side.clip_any) begin
      if (c1_side.clip0) c2_e0 = c_new;
      else c2_e1 = c_new;
    end
  end

  wsp_pkg::point_t p0_e0, p0_e1;

  always_ff @(posedge clk) begin
    if (rst) c2_valid <= 1'b0;
    else c2_valid <= c1_side.valid;
  end

  always_ff @(posedge clk) begin
    c2_visible <= c1_side.visible;
    p0_e0      <= c2_e0;
    p0_e1      <= c2_e1;
  end

  // --------------------------------------------------------------------------
  // Projection set-up. Lanes: left x, right x, left floor, right floor,
  // left ceiling, right ceiling. Stage 1 scales by 200, stage 2 splits off
  // the sign so the divider sees magnitudes only.
  // --------------------------------------------------------------------------
  wsp_pkg::val_t                         lane_val [wsp_pkg::LANES];
  logic signed [wsp_pkg::PROJ_NUM_W-1:0] p1_num   [wsp_pkg::LANES];
  logic [wsp_pkg::PROJ_NUM_W-1:0]        p2_mag   [wsp_pkg::LANES];
  logic [wsp_pkg::PROJ_NUM_W-1:0]        lane_quo [wsp_pkg::LANES];
  logic [wsp_pkg::LANES-1:0]             p2_sign;
  logic [wsp_pkg::PROJ_DEN_W-1:0]        p1_den0, p1_den1, p2_den0, p2_den1;
  logic                                  p1_valid, p1_visible, p2_valid, p2_visible;

  always_comb begin
    lane_val[0] = p0_e0.px;
    lane_val[1] = p0_e1.px;
    lane_val[2] = p0_e0.zb;
    lane_val[3] = p0_e1.zb;
    lane_val[4] = p0_e0.zt;
    lane_val[5] = p0_e1.zt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= c2_valid;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_visible <= c2_visible;
    p1_den0    <= wsp_pkg::PROJ_DEN_W'(p0_e0.py);
    p1_den1    <= wsp_pkg::PROJ_DEN_W'(p0_e1.py);
    p2_visible <= p1_visible;
    p2_den0    <= p1_den0;
    p2_den1    <= p1_den1;
  end

  wsp_pkg::proj_side_t pside_in, pside_out;

  always_comb begin
    pside_in.valid   = p2_valid;
    pside_in.visible = p2_visible;
    pside_in.sign    = p2_sign;
  end

  for (genvar j = 0; j < wsp_pkg::LANES; j++) begin : g_lane
    always_ff @(posedge clk) begin
      p1_num[j]  <= wsp_pkg::PROJ_NUM_W'(lane_val[j]) *
                    wsp_pkg::PROJ_NUM_W'(wsp_pkg::PROJ_SCALE);
      p2_sign[j] <= p1_num[j][wsp_pkg::PROJ_NUM_W-1];
      p2_mag[j]  <= p1_num[j][wsp_pkg::PROJ_NUM_W-1] ? -p1_num[j] : p1_num[j];
    end

    // odd lanes belong to the right endpoint
    wsp_div #(
      .NUM_W (wsp_pkg::PROJ_NUM_W),
      .DEN_W (wsp_pkg::PROJ_DEN_W)
    ) u_proj_div (
      .clk (clk),
      .num (p2_mag[j]),
      .den (((j & 1) != 0) ? p2_den1 : p2_den0),
      .quo (lane_quo[j])
    );
  end

  wsp_delay #(
    .W     ($bits(wsp_pkg::proj_side_t)),
    .DEPTH (wsp_pkg::PROJ_NUM_W)
  ) u_proj_delay (
    .clk (clk),
    .rst (rst),
    .d   (pside_in),
    .q   (pside_out)
  );

  // --------------------------------------------------------------------------
  // Output: restore sign, add the screen centre, saturate, and drop to zero
  // for a culled wall.
  // --------------------------------------------------------------------------
  logic signed [wsp_pkg::PROJ_SUM_W-1:0] q_signed [wsp_pkg::LANES];
  logic signed [wsp_pkg::PROJ_SUM_W-1:0] q_sum    [wsp_pkg::LANES];
  logic signed [wsp_pkg::OUT_W-1:0]      q_sat    [wsp_pkg::LANES];
  logic signed [wsp_pkg::OUT_W-1:0]      out_val  [wsp_pkg::LANES];

  for (genvar j = 0; j < wsp_pkg::LANES; j++) begin : g_out
    always_comb begin
      q_signed[j] = $signed(wsp_pkg::PROJ_SUM_W'(lane_quo[j]));
      if (pside_out.sign[j]) q_signed[j] = -q_signed[j];
      q_sum[j] = q_signed[j] + wsp_pkg::PROJ_SUM_W'((j < 2) ? HALF_SCREEN_W : HALF_SCREEN_H);
      if (q_sum[j] > SAT_MAX) q_sat[j] = wsp_pkg::OUT_W'(SAT_MAX);
      else if (q_sum[j] < SAT_MIN) q_sat[j] = wsp_pkg::OUT_W'(SAT_MIN);
      else q_sat[j] = wsp_pkg::OUT_W'(q_sum[j]);
    end

    always_ff @(posedge clk) begin
      out_val[j] <= pside_out.visible ? q_sat[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= pside_out.valid;
  end

  always_ff @(posedge clk) begin
    visible <= pside_out.visible;
  end

  assign screen_left_x  = out_val[0];
  assign screen_right_x = out_val[1];
  assign bottom_left_y  = out_val[2];
  assign bottom_right_y = out_val[3];
  assign top_left_y     = out_val[4];
  assign top_right_y    = out_val[5];

endmodule
